[design/dhot_pkg.sv]
// package for the double hash open table unit
// operation codes, sequencer states, sizes and shared types; no dependencies
package dhot_pkg;

	// table geometry and field widths
	localparam int SLOTS      = 1024;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIPE,
		ST_MOD,
		ST_RD,
		ST_CHK,
		ST_CRD,
		ST_CCHK,
		ST_WR2,
		ST_OUT
	} state_t;

	localparam logic [9:0] SIZE_RESET = 10'd1021;
	localparam int unsigned MIN_SIZE = 19;

	// status and result of one request
	typedef struct packed {
		logic        found;
		logic [31:0] found_value;
		logic        status;
		logic [10:0] used_count;
	} result_t;

endpackage

[design/double_hash_open_table_unit.sv]
// top level of the double hash open table unit
// uses dhot_pkg, dhot_ram (slot store) and dhot_modu (hash remainders)
//
// channel | dir | contents
// s_axis  | in  | tuser operation, tdata key then value
// m_axis  | out | tdata found, found_value, status, used_count
// cfg     | in  | table_size write
//
// one request at a time: for a non-zero key, key mod S and key mod S-2 run in
// turn on one serial remainder unit, then each probe reads the single port
// slot memory in ST_RD and ST_CHK; an insert that meets a tombstone then
// searches on for a copy, each probe in ST_CRD and ST_CCHK. clear and reset
// sweep every slot, one a cycle, with s_axis_tready low. a result waits in the
// output register; the next word is taken as soon as it has left.
module double_hash_open_table_unit
	import dhot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // found, found_value, status, used_count
);

	localparam int AW = $clog2(SLOTS);
	localparam int SW = $clog2(SLOTS + 1);
	localparam int EW = KEY_BITS + VALUE_BITS + 1;

	state_t state_q, state_d;
	logic [9:0]  size_cfg_q;
	logic [SW-1:0] s_q;
	op_t op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic zp_q;
	logic [VALUE_BITS-1:0] zv_q;
	logic [10:0] fill_q;
	logic [AW-1:0] h_q, incr_q, tgt_q, g_q, wipe_q;
	logic [SW-1:0] n_q;
	logic phase_q;
	logic boot_q;
	result_t res_q;
	logic out_v_q;
	logic m_start_q;

	// slot memory: {deleted, value, key}
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [KEY_BITS-1:0] rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic rd_del;

	assign rd_key = ram_rdata[KEY_BITS-1:0];
	assign rd_val = ram_rdata[KEY_BITS +: VALUE_BITS];
	assign rd_del = ram_rdata[EW-1];

	dhot_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// hash remainder unit, first run starts on the incoming key
	logic m_start, m_busy;
	logic [SW-1:0] m_div, m_rem;
	logic [KEY_BITS-1:0] m_dividend;
	assign m_dividend = (state_q == ST_IDLE) ? s_axis_tdata[KEY_BITS-1:0] : key_q;
	dhot_modu #(.KW(KEY_BITS), .DW(SW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(m_start), .dividend(m_dividend),
		.divisor(m_div), .busy(m_busy), .rem(m_rem)
	);
	assign m_div = phase_q ? s_q - SW'(2) : s_q;

	// clamped size
	always_comb begin
		if (size_cfg_q < 10'(MIN_SIZE)) s_q = SW'(MIN_SIZE);
		else if (32'(size_cfg_q) > 32'(SLOTS)) s_q = SW'(SLOTS);
		else s_q = SW'(size_cfg_q);
	end

	function automatic logic [AW-1:0] step(input logic [AW-1:0] a,
		input logic [AW-1:0] b, input logic [SW-1:0] s);
		logic [SW:0] t;
		t = {1'b0, SW'(a)} + {1'b0, SW'(b)};
		if (t >= {1'b0, s}) t = t - {1'b0, s};
		return AW'(t);
	endfunction

	logic accept;
	logic [AW-1:0] h_next, g_next;
	logic load_ok;
	logic [16:0] lim;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign h_next = step(h_q, incr_q, s_q);
	assign g_next = step(g_q, incr_q, s_q);
	assign lim = (17'd21 * (17'(fill_q) + 17'd1)) >> 4;
	assign load_ok = !(17'(s_q) < lim);
	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_WIPE;
		else state_q <= state_d;
	end

	// sequencer next state and memory control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = h_q;
		ram_wdata = '0;
		m_start   = 1'b0;
		case (state_q)
			ST_IDLE: if (accept) begin
				if (op_t'(s_axis_tuser) == OP_CLEAR) state_d = ST_WIPE;
				else if (s_axis_tdata[KEY_BITS-1:0] == '0) state_d = ST_OUT;
				else begin
					state_d = ST_MOD;
				end
			end
			ST_WIPE: begin
				ram_we   = 1'b1;
				ram_addr = wipe_q;
				if (32'(wipe_q) == SLOTS - 1) state_d = boot_q ? ST_IDLE : ST_OUT;
			end
			// remainder sequencing follows the case
			ST_MOD: ;
			ST_RD: state_d = ST_CHK;
			ST_CHK: begin
				if (rd_key == key_q) begin
					if (op_q == OP_INSERT) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b0, val_q, key_q};
					end else if (op_q == OP_REMOVE) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, VALUE_BITS'(0), KEY_BITS'(0)};
					end
					state_d = ST_OUT;
				end else if (rd_key == '0 && (op_q == OP_INSERT || !rd_del)) begin
					if (op_q != OP_INSERT) state_d = ST_OUT;
					else if (rd_del && SW'(s_q - 1) != '0) state_d = ST_CRD;
					else state_d = ST_WR2;
				end else if (n_q + 1'b1 >= s_q) state_d = ST_OUT;
				else state_d = ST_RD;
				if (state_d == ST_RD) ram_addr = h_next;
			end
			ST_CRD: begin
				ram_addr = g_q;
				state_d  = ST_CCHK;
			end
			ST_CCHK: begin
				ram_addr = g_q;
				if (rd_key == key_q) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, VALUE_BITS'(0), KEY_BITS'(0)};
					state_d   = ST_WR2;
				end else if ((rd_key == '0 && !rd_del) || n_q + 1'b1 >= s_q) begin
					state_d = ST_WR2;
				end else state_d = ST_CRD;
			end
			ST_WR2: begin
				ram_addr = tgt_q;
				if (res_q.found || load_ok) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b0, val_q, key_q};
				end
				state_d = ST_OUT;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && accept && state_d == ST_MOD) m_start = 1'b1;
		if (state_q == ST_MOD && !m_busy && !phase_q && !m_start_q) m_start = 1'b1;
		if (state_q == ST_MOD && !m_busy && phase_q && !m_start_q) begin
			state_d  = ST_RD;
			ram_addr = h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_start_q <= 1'b0;
		else m_start_q <= m_start;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= SIZE_RESET;
			zp_q       <= 1'b0;
			fill_q     <= '0;
			out_v_q    <= 1'b0;
			wipe_q     <= '0;
			phase_q    <= 1'b0;
			boot_q     <= 1'b1;
		end else begin
			if (cfg_we) size_cfg_q <= cfg_wdata;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					phase_q <= 1'b0;
					if (op_t'(s_axis_tuser) == OP_CLEAR) begin
						zp_q   <= 1'b0;
						fill_q <= '0;
					end else if (s_axis_tdata[KEY_BITS-1:0] == '0) begin
						if (op_t'(s_axis_tuser) == OP_INSERT) zp_q <= 1'b1;
						else if (op_t'(s_axis_tuser) == OP_REMOVE) zp_q <= 1'b0;
					end
				end
				ST_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (32'(wipe_q) == SLOTS - 1) boot_q <= 1'b0;
				end
				ST_MOD: if (!m_busy && !m_start_q && !phase_q) phase_q <= 1'b1;
				ST_WR2: if (!res_q.found && load_ok) fill_q <= fill_q + 1'b1;
				ST_OUT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				op_q  <= op_t'(s_axis_tuser);
				key_q <= s_axis_tdata[KEY_BITS-1:0];
				val_q <= s_axis_tdata[32 +: VALUE_BITS];
				n_q   <= '0;
				res_q.status     <= 1'b0;
				res_q.used_count <= '0;
				if (s_axis_tdata[KEY_BITS-1:0] == '0 &&
					(op_t'(s_axis_tuser) == OP_LOOKUP || op_t'(s_axis_tuser) == OP_INSERT)) begin
					res_q.found       <= zp_q;
					res_q.found_value <= zp_q ? 32'(zv_q) : 32'd0;
				end else begin
					res_q.found       <= 1'b0;
					res_q.found_value <= 32'd0;
				end
				if (s_axis_tdata[KEY_BITS-1:0] == '0) begin
					if (op_t'(s_axis_tuser) == OP_INSERT) zv_q <= s_axis_tdata[32 +: VALUE_BITS];
					else if (op_t'(s_axis_tuser) == OP_REMOVE) zv_q <= '0;
				end else if (op_t'(s_axis_tuser) == OP_CLEAR) zv_q <= '0;
			end
			ST_MOD: if (!m_busy && !m_start_q) begin
				if (!phase_q) h_q <= AW'(m_rem);
				else incr_q <= AW'(m_rem + 1'b1);
			end
			ST_CHK: begin
				if (rd_key == key_q) begin
					if (op_q != OP_REMOVE) begin
						res_q.found       <= 1'b1;
						res_q.found_value <= 32'(rd_val);
					end
				end else if (rd_key == '0 && (op_q == OP_INSERT || !rd_del)) begin
					tgt_q <= h_q;
					g_q   <= h_next;
					n_q   <= SW'(1);
				end else if (n_q + 1'b1 >= s_q) begin
					if (op_q == OP_INSERT) res_q.status <= 1'b1;
				end else begin
					h_q <= h_next;
					n_q <= n_q + 1'b1;
				end
			end
			ST_CCHK: if (rd_key == key_q) begin
				res_q.found       <= 1'b1;
				res_q.found_value <= 32'(rd_val);
			end else begin
				g_q <= g_next;
				n_q <= n_q + 1'b1;
			end
			ST_WR2: if (!res_q.found && !load_ok) res_q.status <= 1'b1;
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b0, fill_q, res_q.status, res_q.found_value, res_q.found};

	// a result never appears while the sequencer is busy on another word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> state_q == ST_IDLE || state_q == ST_OUT)
		else $error("result pending while busy");
	// nothing is accepted during a wipe
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WIPE |-> !s_axis_tready)
		else $error("accept during wipe");
	// fill count changes only after an insert or clear
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> $past(state_q) == ST_WR2 || $past(state_q) == ST_IDLE)
		else $error("stray fill change");

endmodule

[design/dhot_ram.sv]
// generic single port synchronous ram with registered read
// no dependencies
module dhot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read registered, a read during a write returns the old contents
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

[design/dhot_modu.sv]
// serial remainder unit: key mod a divisor, one bit per cycle
// depends on nothing but the clock and reset
module dhot_modu #(
	parameter int KW = 32,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(KW + 1);

	logic [KW-1:0] sh_q;
	logic [DW:0]   r_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;

	assign trial = {r_q[DW-1:0], sh_q[KW-1]};
	assign busy  = (cnt_q != '0);
	assign rem   = r_q[DW-1:0];

	// restoring division, remainder only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(KW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			r_q  <= '0;
		end else if (busy) begin
			sh_q <= sh_q << 1;
			if (trial >= {1'b0, divisor}) r_q <= trial - {1'b0, divisor};
			else r_q <= trial;
		end
	end

endmodule

[sim/tb_double_hash_open_table_unit.sv]
// testbench for the double hash open table unit: random and directed table requests
// depends on dhot_pkg and double_hash_open_table_unit; checks every reply word
`timescale 1ns / 100ps

// table mirror and reply checker
class table_scoreboard;
	bit [31:0]   slot_key [1024];
	bit [31:0]   slot_val [1024];
	bit          slot_dead [1024];
	bit          zero_there;
	bit [31:0]   zero_val;
	bit [10:0]   fill;
	bit [9:0]    size_reg;
	dhot_pkg::result_t pending_replies [$];
	int          errors;

	function new();
		size_reg = dhot_pkg::SIZE_RESET;
		wipe();
		errors = 0;
	endfunction

	function void wipe();
		foreach (slot_key[i]) begin
			slot_key[i] = 0;
			slot_val[i] = 0;
			slot_dead[i] = 0;
		end
		zero_there = 0;
		zero_val = 0;
		fill = 0;
	endfunction

	function int unsigned step_slot(int unsigned h, int unsigned inc, int unsigned s);
		h = h + inc;
		if (h >= s) h = h - s;
		return h;
	endfunction

	// predict the reply of one accepted request
	function void note_request(dhot_pkg::op_t op, bit [31:0] k, bit [31:0] v);
		dhot_pkg::result_t r;
		int unsigned s, h, inc, n, tgt, cp, g;
		bit hit, have_tgt, done, have_cp;
		r = '0;
		s = size_reg;
		if (s < dhot_pkg::MIN_SIZE) s = dhot_pkg::MIN_SIZE;
		if (s > 1024) s = 1024;
		h = k % s;
		inc = 1 + k % (s - 2);
		if (op == dhot_pkg::OP_CLEAR) begin
			wipe();
		end else if (k == 0) begin
			if (op != dhot_pkg::OP_REMOVE) begin
				r.found = zero_there;
				r.found_value = zero_there ? zero_val : 0;
			end
			if (op == dhot_pkg::OP_INSERT) begin
				zero_there = 1;
				zero_val = v;
			end else if (op == dhot_pkg::OP_REMOVE) begin
				zero_there = 0;
				zero_val = 0;
			end
		end else if (op != dhot_pkg::OP_INSERT) begin
			hit = 0;
			for (n = 0; n < s; n++) begin
				if (slot_key[h] == k) begin
					hit = 1;
					break;
				end
				if (slot_key[h] == 0 && !slot_dead[h]) break;
				h = step_slot(h, inc, s);
			end
			if (hit && op == dhot_pkg::OP_LOOKUP) begin
				r.found = 1;
				r.found_value = slot_val[h];
			end else if (hit) begin
				slot_key[h] = 0;
				slot_val[h] = 0;
				slot_dead[h] = 1;
			end
		end else begin
			have_tgt = 0;
			done = 0;
			tgt = 0;
			for (n = 0; n < s; n++) begin
				if (slot_key[h] == k) begin
					r.found = 1;
					r.found_value = slot_val[h];
					slot_val[h] = v;
					done = 1;
					break;
				end
				if (slot_key[h] == 0) begin
					tgt = h;
					have_tgt = 1;
					break;
				end
				h = step_slot(h, inc, s);
			end
			if (!done && !have_tgt) begin
				r.status = 1;
			end else if (!done) begin
				// landed on a tombstone: look for a later copy of the key
				have_cp = 0;
				cp = 0;
				if (slot_dead[tgt]) begin
					g = tgt;
					for (n = 1; n < s; n++) begin
						g = step_slot(g, inc, s);
						if (slot_key[g] == k) begin
							cp = g;
							have_cp = 1;
							break;
						end
						if (slot_key[g] == 0 && !slot_dead[g]) break;
					end
				end
				if (have_cp) begin
					r.found = 1;
					r.found_value = slot_val[cp];
					slot_key[tgt] = k;
					slot_val[tgt] = v;
					slot_dead[tgt] = 0;
					slot_key[cp] = 0;
					slot_val[cp] = 0;
					slot_dead[cp] = 1;
				end else if (s < (21 * (int'(fill) + 1)) / 16) begin
					r.status = 1;
				end else begin
					slot_key[tgt] = k;
					slot_val[tgt] = v;
					slot_dead[tgt] = 0;
					fill = fill + 1;
				end
			end
		end
		r.used_count = fill;
		pending_replies.push_back(r);
	endfunction

	// compare one reply word with the oldest prediction
	function void check_reply(dhot_pkg::result_t got);
		dhot_pkg::result_t exp_r;
		if (pending_replies.size() == 0) begin
			$error("reply word with no request waiting");
			errors++;
			return;
		end
		exp_r = pending_replies.pop_front();
		if (got.found !== exp_r.found) begin
			$error("found expected %0d actual %0d", exp_r.found, got.found);
			errors++;
		end
		if (got.found_value !== exp_r.found_value) begin
			$error("found_value expected %h actual %h", exp_r.found_value, got.found_value);
			errors++;
		end
		if (got.status !== exp_r.status) begin
			$error("status expected %0d actual %0d", exp_r.status, got.status);
			errors++;
		end
		if (got.used_count !== exp_r.used_count) begin
			$error("used_count expected %0d actual %0d", exp_r.used_count, got.used_count);
			errors++;
		end
	endfunction
endclass

module tb_double_hash_open_table_unit;
	import dhot_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [9:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	table_scoreboard sb;
	int          cycles;
	int          words_out;
	int          hold;
	bit          pressure_done;

	double_hash_open_table_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// split a reply word into its fields
	function automatic result_t unpack_reply(logic [47:0] d);
		result_t r;
		r.found       = d[0];
		r.found_value = d[32:1];
		r.status      = d[33];
		r.used_count  = d[44:34];
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		m_axis_tready = 0;
		hold = 0;
		words_out = 0;
		pressure_done = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				sb.check_reply(unpack_reply(m_axis_tdata));
				words_out++;
				hold = $urandom_range(0, 4);
				if ($urandom_range(0, 3) == 0) hold = 0;
				if (!pressure_done && words_out == 100) begin
					hold = 3000;
					pressure_done = 1;
				end
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// offer one request word and wait for it to be taken
	task automatic send_word(op_t op, bit [31:0] k, bit [31:0] v);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {v, k};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, k, v);
	endtask

	// set the table size once every reply is back
	task automatic set_size(bit [9:0] sz);
		s_axis_tvalid <= 0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= sz;
		@(posedge clk);
		cfg_we <= 0;
		sb.size_reg = sz;
	endtask

	task automatic random_words(int count, int unsigned s);
		int r;
		bit [31:0] k;
		op_t op;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) op = OP_INSERT;
			else if (r < 75) op = OP_LOOKUP;
			else if (r < 97) op = OP_REMOVE;
			else op = OP_CLEAR;
			r = $urandom_range(0, 9);
			if (r == 0) k = 0;
			else if (r == 1) k = $urandom;
			else k = $urandom_range(1, 3 * s);
			send_word(op, k, $urandom);
		end
	endtask

	initial begin
		bit [9:0] sizes [6];
		int unsigned s;
		sizes = '{10'd19, 10'd1021, 10'd5, 10'd97, 10'd1023, 10'd31};
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = OP_LOOKUP;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// reset size first, then the configured phases
		random_words(30, 1021);
		foreach (sizes[p]) begin
			set_size(sizes[p]);
			s = sizes[p] < 19 ? 19 : sizes[p];
			send_word(OP_CLEAR, 0, 0);
			if (p == 0) begin
				// zero key side slot
				send_word(OP_LOOKUP, 0, 0);
				send_word(OP_INSERT, 0, 32'hFFFFFFFF);
				send_word(OP_INSERT, 0, 32'h1);
				send_word(OP_LOOKUP, 0, 0);
				send_word(OP_REMOVE, 0, 0);
				send_word(OP_LOOKUP, 0, 0);
				// extremes, replace, miss
				send_word(OP_INSERT, 32'hFFFFFFFF, 32'h0);
				send_word(OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF);
				send_word(OP_LOOKUP, 32'hFFFFFFFF, 0);
				send_word(OP_LOOKUP, 32'h12345678, 0);
				// tombstone then later copy of the same key
				send_word(OP_INSERT, 5, 32'hA5A5A5A5);
				send_word(OP_INSERT, 24, 32'h5A5A5A5A);
				send_word(OP_REMOVE, 5, 0);
				send_word(OP_INSERT, 24, 32'hDEADBEEF);
				send_word(OP_LOOKUP, 24, 0);
				send_word(OP_REMOVE, 77, 0);
				// fill up to the load limit
				for (int j = 1; j <= 16; j++) send_word(OP_INSERT, j * 7, j);
			end
			random_words(100, s);
		end

		s_axis_tvalid <= 0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
